>>> sv/acw_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and microprogram of the aspect crop window unit
package acw_pkg;

  // coordinate width default and configuration register map
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ASPECT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ASPECT_HEIGHT = 2'd3;

  localparam int FRAME_WIDTH_RST   = 640;
  localparam int FRAME_HEIGHT_RST  = 480;
  localparam int ASPECT_WIDTH_RST  = 4;
  localparam int ASPECT_HEIGHT_RST = 3;

  // microprogram step addresses
  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t S_LOAD  = 4'd0;
  localparam step_t S_GTEST = 4'd1;
  localparam step_t S_GMOD  = 4'd2;
  localparam step_t S_RW    = 4'd3;
  localparam step_t S_RH    = 4'd4;
  localparam step_t S_TX    = 4'd5;
  localparam step_t S_TY    = 4'd6;
  localparam step_t S_MIN   = 4'd7;
  localparam step_t S_MULW  = 4'd8;
  localparam step_t S_MULH  = 4'd9;
  localparam step_t S_ZERO  = 4'd10;
  localparam step_t S_PLX   = 4'd11;
  localparam step_t S_PLY   = 4'd12;
  localparam step_t S_EMIT  = 4'd13;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LOAD    = 4'd1,
    OP_DIV     = 4'd2,
    OP_MIN     = 4'd3,
    OP_MUL_W   = 4'd4,
    OP_MUL_H   = 4'd5,
    OP_ZERO    = 4'd6,
    OP_PLACE_X = 4'd7,
    OP_PLACE_Y = 4'd8,
    OP_EMIT    = 4'd9
  } op_t;

  // operand pair for the shared divider
  typedef enum logic [2:0] {
    DS_GCD = 3'd0,
    DS_RW  = 3'd1,
    DS_RH  = 3'd2,
    DS_TX  = 3'd3,
    DS_TY  = 3'd4
  } dsel_t;

  // jump condition
  typedef enum logic [1:0] {
    C_NEXT        = 2'd0,
    C_ALWAYS      = 2'd1,
    C_ASPECT_ZERO = 2'd2,
    C_B_ZERO      = 2'd3
  } cond_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    cond_t cond;
    step_t target;
  } ctl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic hold;
    logic aspect_zero;
    logic b_zero;
  } status_t;

  function automatic ctl_t ctl_word(input op_t op, input dsel_t dsel, input cond_t cond,
                                    input step_t target);
    ctl_t w;
    w.op     = op;
    w.dsel   = dsel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // microprogram rom
  function automatic ctl_t acw_rom(input step_t s);
    ctl_t w;
    unique case (s)
      S_LOAD:  w = ctl_word(OP_LOAD,    DS_GCD, C_ASPECT_ZERO, S_ZERO);
      S_GTEST: w = ctl_word(OP_NOP,     DS_GCD, C_B_ZERO,      S_RW);
      S_GMOD:  w = ctl_word(OP_DIV,     DS_GCD, C_ALWAYS,      S_GTEST);
      S_RW:    w = ctl_word(OP_DIV,     DS_RW,  C_NEXT,        S_LOAD);
      S_RH:    w = ctl_word(OP_DIV,     DS_RH,  C_NEXT,        S_LOAD);
      S_TX:    w = ctl_word(OP_DIV,     DS_TX,  C_NEXT,        S_LOAD);
      S_TY:    w = ctl_word(OP_DIV,     DS_TY,  C_NEXT,        S_LOAD);
      S_MIN:   w = ctl_word(OP_MIN,     DS_GCD, C_NEXT,        S_LOAD);
      S_MULW:  w = ctl_word(OP_MUL_W,   DS_GCD, C_NEXT,        S_LOAD);
      S_MULH:  w = ctl_word(OP_MUL_H,   DS_GCD, C_ALWAYS,      S_PLX);
      S_ZERO:  w = ctl_word(OP_ZERO,    DS_GCD, C_NEXT,        S_LOAD);
      S_PLX:   w = ctl_word(OP_PLACE_X, DS_GCD, C_NEXT,        S_LOAD);
      S_PLY:   w = ctl_word(OP_PLACE_Y, DS_GCD, C_NEXT,        S_LOAD);
      S_EMIT:  w = ctl_word(OP_EMIT,    DS_GCD, C_ALWAYS,      S_LOAD);
      default: w = ctl_word(OP_NOP,     DS_GCD, C_ALWAYS,      S_LOAD);
    endcase
    return w;
  endfunction

endpackage

>>> sv/aspect_crop_window_unit.sv
`timescale 1ns / 1ps
// top level of the aspect crop window unit: configuration registers and core
//
// Use: configure the frame extent and the wanted aspect ratio through the cfg_ write
// port (index 0 frame width, 1 frame height, 2 aspect width, 3 aspect height), then
// send centre points on the in_ channel; each item gives one window on the out_
// channel with its lower corner (left, bottom) and upper corner (right, top).
// An item is taken when valid is high and stall is low, on either channel.
// Throughput: one item at a time, run by a microprogram on a shared restoring
// divider. An item runs one division per Euclid remainder step of the aspect
// ratio and four more; with a zero aspect part it runs no division. The next
// item is accepted right after the result is moved into the output register.
// Reset: synchronous, active low; configuration returns to 640 x 480 at 4:3 and
// the output channel goes empty.
// Stall: a stalled result holds on the output register; the core finishes the
// next item and waits at its emit step until the register is free.
module aspect_crop_window_unit #(
  parameter int COORD_BITS = acw_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [acw_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [COORD_BITS-1:0]            cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            in_center_x,
  input  logic [COORD_BITS-1:0]            in_center_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_BITS-1:0]            out_left,
  output logic [COORD_BITS-1:0]            out_bottom,
  output logic [COORD_BITS-1:0]            out_right,
  output logic [COORD_BITS-1:0]            out_top
);
  import acw_pkg::*;

  logic [COORD_BITS-1:0] fw_r, fh_r, aw_r, ah_r;
  ctl_t                  ctl;
  status_t               status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= COORD_BITS'(FRAME_WIDTH_RST);
      fh_r <= COORD_BITS'(FRAME_HEIGHT_RST);
      aw_r <= COORD_BITS'(ASPECT_WIDTH_RST);
      ah_r <= COORD_BITS'(ASPECT_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:   fw_r <= cfg_data;
        REG_FRAME_HEIGHT:  fh_r <= cfg_data;
        REG_ASPECT_WIDTH:  aw_r <= cfg_data;
        REG_ASPECT_HEIGHT: ah_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // microprogram sequencer
  acw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  // datapath
  acw_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .status      (status),
    .cfg_fw      (fw_r),
    .cfg_fh      (fh_r),
    .cfg_aw      (aw_r),
    .cfg_ah      (ah_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_left    (out_left),
    .out_bottom  (out_bottom),
    .out_right   (out_right),
    .out_top     (out_top)
  );

endmodule

>>> sv/acw_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module acw_div #(
  parameter int W = acw_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output logic         done
);
  import acw_pkg::*;

  localparam int CNT_BITS = $clog2(W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [W-1:0]        quo_r;
  logic [W-1:0]        rem_r;
  logic [W-1:0]        dvs_r;
  logic [W:0]          trial;
  logic [W:0]          diff;

  // shift in next dividend bit and try a subtraction
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

  // no restart while a division runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  // result flagged only once the iterations are over
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still iterating");

endmodule

>>> sv/acw_seq.sv
`timescale 1ns / 1ps
// microprogram sequencer: step counter, rom and conditional jumps
module acw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  acw_pkg::status_t status,
  output acw_pkg::ctl_t    ctl
);
  import acw_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  taken;

  assign ctl = acw_rom(step_r);

  // jump condition
  always_comb begin
    unique case (ctl.cond)
      C_NEXT:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_ASPECT_ZERO: taken = status.aspect_zero;
      C_B_ZERO:      taken = status.b_zero;
      default:       taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (status.hold) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

  // the program never runs past its last step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n) step_r <= S_EMIT)
    else $error("sequencer left the microprogram");

endmodule

>>> sv/acw_dp.sv
`timescale 1ns / 1ps
// datapath: operand registers, shared divider, multiplier, placer, output register
module acw_dp #(
  parameter int COORD_BITS = acw_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acw_pkg::ctl_t         ctl,
  output acw_pkg::status_t      status,
  input  logic [COORD_BITS-1:0] cfg_fw,
  input  logic [COORD_BITS-1:0] cfg_fh,
  input  logic [COORD_BITS-1:0] cfg_aw,
  input  logic [COORD_BITS-1:0] cfg_ah,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_left,
  output logic [COORD_BITS-1:0] out_bottom,
  output logic [COORD_BITS-1:0] out_right,
  output logic [COORD_BITS-1:0] out_top
);
  import acw_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int PW = COORD_BITS + 2;

  // working registers
  logic [W-1:0] cx_r, cy_r, a_r, b_r;
  logic [W-1:0] rw_r, rh_r, tx_r, ty_r, t_r;
  logic [W-1:0] wlen_r, hlen_r;
  logic [W-1:0] left_r, right_r, bottom_r, top_r;
  logic [W-1:0] oleft_r, oright_r, obottom_r, otop_r;
  logic         out_valid_r;
  logic         div_pend_r;

  logic         in_fire;
  logic         emit_fire;
  logic         div_start;
  logic         div_done;
  logic         hold;
  logic [W-1:0] div_quo, div_rem;
  logic [W-1:0] div_a, div_b;
  logic [W-1:0] mul_a;
  logic [2*W-1:0] prod;

  // placer signals
  logic [W-1:0]          pc, plen, plim, half;
  logic [W:0]            len_inc;
  logic signed [PW-1:0]  lo0, up0, lo1, slim, slen;
  logic                  over, neg;
  logic [W-1:0]          plo, pup;

  // handshakes
  assign in_stall  = (ctl.op != OP_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (ctl.op == OP_EMIT) && !(out_valid_r && out_stall);
  assign div_start = (ctl.op == OP_DIV) && !div_pend_r;

  // hold the step until its wait is over
  always_comb begin
    unique case (ctl.op)
      OP_LOAD: hold = !in_valid;
      OP_DIV:  hold = !div_done;
      OP_EMIT: hold = out_valid_r && out_stall;
      default: hold = 1'b0;
    endcase
  end
  assign status.hold        = hold;
  assign status.aspect_zero = (cfg_aw == '0) || (cfg_ah == '0);
  assign status.b_zero      = (b_r == '0);

  // divider operand pair
  always_comb begin
    unique case (ctl.dsel)
      DS_GCD:  begin div_a = a_r;    div_b = b_r;  end
      DS_RW:   begin div_a = cfg_aw; div_b = a_r;  end
      DS_RH:   begin div_a = cfg_ah; div_b = a_r;  end
      DS_TX:   begin div_a = cfg_fw; div_b = rw_r; end
      DS_TY:   begin div_a = cfg_fh; div_b = rh_r; end
      default: begin div_a = a_r;    div_b = b_r;  end
    endcase
  end

  acw_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  // one shared multiplier for both window extents
  assign mul_a = (ctl.op == OP_MUL_H) ? rh_r : rw_r;
  assign prod  = mul_a * t_r;

  // axis placement: centre, then pull back inside [0, limit]
  assign pc   = (ctl.op == OP_PLACE_Y) ? cy_r   : cx_r;
  assign plen = (ctl.op == OP_PLACE_Y) ? hlen_r : wlen_r;
  assign plim = (ctl.op == OP_PLACE_Y) ? cfg_fh : cfg_fw;

  assign len_inc = {1'b0, plen} + (W+1)'(1);
  assign half    = len_inc[W:1];
  assign slen    = $signed({2'b00, plen});
  assign slim    = $signed({2'b00, plim});
  assign lo0     = $signed({2'b00, pc}) - $signed({2'b00, half});
  assign up0     = lo0 + slen;
  assign over    = up0 > slim;
  assign lo1     = over ? (slim - slen) : lo0;
  assign neg     = lo1[PW-1];
  assign plo     = neg ? '0 : lo1[W-1:0];
  assign pup     = neg ? plen : (over ? plim : up0[W-1:0]);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      div_pend_r  <= 1'b0;
    end else begin
      if (div_done) begin
        div_pend_r <= 1'b0;
      end else if (div_start) begin
        div_pend_r <= 1'b1;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      a_r  <= cfg_aw;
      b_r  <= cfg_ah;
    end
    if ((ctl.op == OP_DIV) && div_done) begin
      unique case (ctl.dsel)
        DS_GCD: begin
          a_r <= b_r;
          b_r <= div_rem;
        end
        DS_RW:   rw_r <= div_quo;
        DS_RH:   rh_r <= div_quo;
        DS_TX:   tx_r <= div_quo;
        DS_TY:   ty_r <= div_quo;
        default: ;
      endcase
    end
    if (ctl.op == OP_MIN) begin
      t_r <= (tx_r < ty_r) ? tx_r : ty_r;
    end
    if (ctl.op == OP_MUL_W) begin
      wlen_r <= prod[W-1:0];
    end
    if (ctl.op == OP_MUL_H) begin
      hlen_r <= prod[W-1:0];
    end
    if (ctl.op == OP_ZERO) begin
      wlen_r <= '0;
      hlen_r <= '0;
    end
    if (ctl.op == OP_PLACE_X) begin
      left_r  <= plo;
      right_r <= pup;
    end
    if (ctl.op == OP_PLACE_Y) begin
      bottom_r <= plo;
      top_r    <= pup;
    end
    if (emit_fire) begin
      oleft_r   <= left_r;
      obottom_r <= bottom_r;
      oright_r  <= right_r;
      otop_r    <= top_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_left   = oleft_r;
  assign out_bottom = obottom_r;
  assign out_right  = oright_r;
  assign out_top    = otop_r;

  // a division result only arrives for one that was started
  a_div_pending: assert property (@(posedge clk) disable iff (!rst_n) div_done |-> div_pend_r)
    else $error("divider result without a pending division");
  // a new item appears on the output only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == OP_EMIT))
    else $error("output valid raised outside the emit step");
  // placed window lies inside the frame
  a_window_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT) |-> (left_r <= right_r) && (right_r <= cfg_fw) &&
                            (bottom_r <= top_r) && (top_r <= cfg_fh))
    else $error("placed window outside the frame");

endmodule
